### src/mebt_pkg.sv
package mebt_pkg;

  // number formats
  localparam int FX_W    = 48;
  localparam int FRAC_W  = 40;
  localparam int MAG_W   = FX_W - 1;
  localparam int HALF_W  = FX_W / 2;
  localparam int MUL_W   = 2 * FX_W;
  localparam int WIDE_W  = 64;
  localparam int PIX_W   = 10;
  localparam int CNT_W   = 14;
  localparam int MUL_LAT = 4;

  // frame geometry
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 1024;
  localparam int OFF_W        = PIX_W + 4;
  localparam int PROD_W       = OFF_W + FX_W;

  // queue between classifier and iterator
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // fixed point constants
  localparam logic signed [FX_W-1:0] FX_ONE       = FX_W'(64'sd1 <<< FRAC_W);
  localparam logic signed [FX_W-1:0] FX_TWO       = FX_W'(64'sd2 <<< FRAC_W);
  localparam logic signed [FX_W-1:0] FX_QUARTER   = FX_W'(64'sd1 <<< (FRAC_W - 2));
  localparam logic signed [FX_W-1:0] FX_SIXTEENTH = FX_W'(64'sd1 <<< (FRAC_W - 4));
  localparam logic signed [FX_W-1:0] FX_MAX       = {1'b0, {(FX_W-1){1'b1}}};
  localparam logic signed [FX_W-1:0] FX_MIN       = {1'b1, {(FX_W-1){1'b0}}};
  localparam logic signed [WIDE_W-1:0] SAT_HI     = WIDE_W'(FX_MAX);
  localparam logic signed [WIDE_W-1:0] SAT_LO     = WIDE_W'(FX_MIN);

  // configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_REAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IMAG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_RADIUS = 3'd4;

  // configuration reset values
  localparam logic [MAG_W-1:0] PIXEL_STEP_RESET    = MAG_W'(64'd4294967296);
  localparam logic [CNT_W-1:0] MAX_ITER_RESET      = CNT_W'(100);
  localparam logic [MAG_W-1:0] ESCAPE_RADIUS_RESET = MAG_W'(64'd4398046511104);

  typedef struct packed {
    logic signed [FX_W-1:0] center_real;
    logic signed [FX_W-1:0] center_imag;
    logic [MAG_W-1:0]       pixel_step;
    logic [CNT_W-1:0]       max_iterations;
    logic [MAG_W-1:0]       escape_radius_sq;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]       pixel_x;
    logic [PIX_W-1:0]       pixel_y;
    logic signed [FX_W-1:0] c_real;
    logic signed [FX_W-1:0] c_imag;
    logic                   interior;
  } item_t;

  // clamp a wide signed value into the 48-bit range
  function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [WIDE_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v > SAT_HI) begin
      r = FX_MAX;
    end else if (v < SAT_LO) begin
      r = FX_MIN;
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

endpackage

### src/mebt_fxmul.sv
module mebt_fxmul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 go,
  input  logic signed [mebt_pkg::FX_W-1:0]     a,
  input  logic signed [mebt_pkg::FX_W-1:0]     b,
  output logic                                 p_vld,
  output logic signed [mebt_pkg::FX_W-1:0]     p
);

  localparam int FX_W   = mebt_pkg::FX_W;
  localparam int HALF_W = mebt_pkg::HALF_W;
  localparam int MUL_W  = mebt_pkg::MUL_W;
  localparam int FRAC_W = mebt_pkg::FRAC_W;
  localparam int MAG_W  = mebt_pkg::MAG_W;
  localparam int SH_W   = MUL_W - FRAC_W;

  logic [mebt_pkg::MUL_LAT-1:0] vld_r;
  logic [FX_W-1:0]              a_mag_r, b_mag_r;
  logic                         neg0_r, neg1_r, neg2_r;
  logic [FX_W-1:0]              pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [MUL_W-1:0]             full_r;
  logic signed [FX_W-1:0]       p_r;
  logic [SH_W-1:0]              shifted;
  logic [MAG_W-1:0]             mag_sat;

  // valid follows the fixed pipeline depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[mebt_pkg::MUL_LAT-2:0], go};
    end
  end

  // truncate toward zero, clamp the magnitude, then apply the sign
  assign shifted = full_r[MUL_W-1:FRAC_W];
  assign mag_sat = (|shifted[SH_W-1:MAG_W]) ? {MAG_W{1'b1}} : shifted[MAG_W-1:0];

  always_ff @(posedge clk) begin
    // magnitudes and sign
    a_mag_r <= a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
    b_mag_r <= b[FX_W-1] ? FX_W'(-b) : FX_W'(b);
    neg0_r  <= a[FX_W-1] ^ b[FX_W-1];
    // four half-width partial products
    pp_ll_r <= {{HALF_W{1'b0}}, a_mag_r[HALF_W-1:0]} * {{HALF_W{1'b0}}, b_mag_r[HALF_W-1:0]};
    pp_lh_r <= {{HALF_W{1'b0}}, a_mag_r[HALF_W-1:0]} * {{HALF_W{1'b0}}, b_mag_r[FX_W-1:HALF_W]};
    pp_hl_r <= {{HALF_W{1'b0}}, a_mag_r[FX_W-1:HALF_W]} * {{HALF_W{1'b0}}, b_mag_r[HALF_W-1:0]};
    pp_hh_r <= {{HALF_W{1'b0}}, a_mag_r[FX_W-1:HALF_W]} * {{HALF_W{1'b0}}, b_mag_r[FX_W-1:HALF_W]};
    neg1_r  <= neg0_r;
    // combine
    full_r  <= (MUL_W'(pp_hh_r) << FX_W) + (MUL_W'(pp_lh_r) << HALF_W)
             + (MUL_W'(pp_hl_r) << HALF_W) + MUL_W'(pp_ll_r);
    neg2_r  <= neg1_r;
    // signed result
    p_r     <= neg2_r ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
  end

  assign p_vld = vld_r[mebt_pkg::MUL_LAT-1];
  assign p     = p_r;

endmodule

### src/mebt_front.sv
module mebt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mebt_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mebt_pkg::PIX_W-1:0]        in_pixel_x,
  input  logic [mebt_pkg::PIX_W-1:0]        in_pixel_y,
  output logic                              push,
  output mebt_pkg::item_t                   push_item,
  input  logic                              q_full
);

  localparam int FX_W   = mebt_pkg::FX_W;
  localparam int PIX_W  = mebt_pkg::PIX_W;
  localparam int OFF_W  = mebt_pkg::OFF_W;
  localparam int PROD_W = mebt_pkg::PROD_W;
  localparam int WIDE_W = mebt_pkg::WIDE_W;
  localparam logic signed [OFF_W-1:0] FRAME_W_OFF = OFF_W'(mebt_pkg::FRAME_WIDTH);
  localparam logic signed [OFF_W-1:0] FRAME_H_OFF = OFF_W'(mebt_pkg::FRAME_HEIGHT);

  typedef enum logic [3:0] {
    F_IDLE, F_MAP, F_ADD, F_BOX, F_MUL_CI, F_MUL_T, F_MUL_U,
    F_SUM_Q, F_SUM_QT, F_MUL_Q, F_DECIDE, F_PUSH
  } state_t;

  state_t                   state_r;
  logic [PIX_W-1:0]         px_r, py_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  logic signed [FX_W-1:0]   cr_r, ci_r, t_r, u_r;
  logic signed [FX_W-1:0]   ci2_r, tt_r, uu_r, q_r, lhs_r;
  logic                     interior_r;
  logic                     mul_go_r;
  logic signed [FX_W-1:0]   mul_a_r, mul_b_r;
  logic                     mul_vld;
  logic signed [FX_W-1:0]   mul_p;

  logic signed [OFF_W-1:0]  off_x, off_y;
  logic signed [PROD_W-1:0] off_x_w, off_y_w, step_w;
  logic signed [FX_W-1:0]   cr_nxt, ci_nxt, t_nxt, u_nxt, q_nxt, qt;
  logic                     in_box, in_cardioid, in_bulb;

  // pixel offset from the frame middle, doubled so odd frame sizes stay exact
  assign off_x   = $signed({{(OFF_W-PIX_W-1){1'b0}}, px_r, 1'b0}) - FRAME_W_OFF;
  assign off_y   = $signed({{(OFF_W-PIX_W-1){1'b0}}, py_r, 1'b0}) - FRAME_H_OFF;
  assign off_x_w = PROD_W'(off_x);
  assign off_y_w = PROD_W'(off_y);
  assign step_w  = $signed(PROD_W'(cfg.pixel_step));

  // halve with floor, add the view center
  assign cr_nxt = mebt_pkg::sat_fx(WIDE_W'(prod_x_r >>> 1) + WIDE_W'($signed(cfg.center_real)));
  assign ci_nxt = mebt_pkg::sat_fx(WIDE_W'(prod_y_r >>> 1) + WIDE_W'($signed(cfg.center_imag)));

  // cardioid and bulb operands
  assign in_box = (cr_r > -mebt_pkg::FX_TWO) && (cr_r < mebt_pkg::FX_TWO)
               && (ci_r > -mebt_pkg::FX_TWO) && (ci_r < mebt_pkg::FX_TWO);
  assign t_nxt  = mebt_pkg::sat_fx(WIDE_W'(cr_r) - WIDE_W'(mebt_pkg::FX_QUARTER));
  assign u_nxt  = mebt_pkg::sat_fx(WIDE_W'(cr_r) + WIDE_W'(mebt_pkg::FX_ONE));
  assign q_nxt  = mebt_pkg::sat_fx(WIDE_W'(tt_r) + WIDE_W'(ci2_r));
  assign qt     = mebt_pkg::sat_fx(WIDE_W'(q_r) + WIDE_W'(t_r));

  assign in_cardioid = lhs_r < (ci2_r >>> 2);
  assign in_bulb     = (WIDE_W'(uu_r) + WIDE_W'(ci2_r)) < WIDE_W'(mebt_pkg::FX_SIXTEENTH);

  // shared multiplier for the classification products
  mebt_fxmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .p_vld (mul_vld),
    .p     (mul_p)
  );

  // classifier sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      mul_go_r <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            px_r    <= in_pixel_x;
            py_r    <= in_pixel_y;
            state_r <= F_MAP;
          end
        end
        F_MAP: begin
          prod_x_r <= off_x_w * step_w;
          prod_y_r <= off_y_w * step_w;
          state_r  <= F_ADD;
        end
        F_ADD: begin
          cr_r    <= cr_nxt;
          ci_r    <= ci_nxt;
          state_r <= F_BOX;
        end
        F_BOX: begin
          t_r <= t_nxt;
          u_r <= u_nxt;
          if (in_box) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= ci_r;
            mul_b_r  <= ci_r;
            state_r  <= F_MUL_CI;
          end else begin
            interior_r <= 1'b0;
            state_r    <= F_PUSH;
          end
        end
        F_MUL_CI: begin
          if (mul_vld) begin
            ci2_r    <= mul_p;
            mul_go_r <= 1'b1;
            mul_a_r  <= t_r;
            mul_b_r  <= t_r;
            state_r  <= F_MUL_T;
          end
        end
        F_MUL_T: begin
          if (mul_vld) begin
            tt_r     <= mul_p;
            mul_go_r <= 1'b1;
            mul_a_r  <= u_r;
            mul_b_r  <= u_r;
            state_r  <= F_MUL_U;
          end
        end
        F_MUL_U: begin
          if (mul_vld) begin
            uu_r    <= mul_p;
            state_r <= F_SUM_Q;
          end
        end
        F_SUM_Q: begin
          q_r     <= q_nxt;
          state_r <= F_SUM_QT;
        end
        F_SUM_QT: begin
          mul_go_r <= 1'b1;
          mul_a_r  <= q_r;
          mul_b_r  <= qt;
          state_r  <= F_MUL_Q;
        end
        F_MUL_Q: begin
          if (mul_vld) begin
            lhs_r   <= mul_p;
            state_r <= F_DECIDE;
          end
        end
        F_DECIDE: begin
          interior_r <= in_cardioid || in_bulb;
          state_r    <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH) && !q_full;

  assign push_item.pixel_x  = px_r;
  assign push_item.pixel_y  = py_r;
  assign push_item.c_real   = cr_r;
  assign push_item.c_imag   = ci_r;
  assign push_item.interior = interior_r;

endmodule

### src/mebt_queue.sv
module mebt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mebt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output mebt_pkg::item_t pop_item,
  output logic            empty
);

  localparam int DEPTH  = mebt_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = mebt_pkg::QPTR_W;
  localparam int CNT_W  = mebt_pkg::QCNT_W;

  mebt_pkg::item_t   slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item = slot_r[rd_ptr_r];
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

endmodule

### src/mebt_back.sv
module mebt_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mebt_pkg::cfg_t                cfg,
  output logic                          pop,
  input  mebt_pkg::item_t               pop_item,
  input  logic                          q_empty,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mebt_pkg::PIX_W-1:0]    out_x,
  output logic [mebt_pkg::PIX_W-1:0]    out_y,
  output logic [mebt_pkg::CNT_W-1:0]    out_iteration_count,
  output logic                          out_interior,
  output logic [mebt_pkg::MAG_W-1:0]    out_final_magnitude_sq
);

  localparam int FX_W   = mebt_pkg::FX_W;
  localparam int MAG_W  = mebt_pkg::MAG_W;
  localparam int PIX_W  = mebt_pkg::PIX_W;
  localparam int CNT_W  = mebt_pkg::CNT_W;
  localparam int WIDE_W = mebt_pkg::WIDE_W;

  typedef enum logic [1:0] {B_IDLE, B_STEP, B_WAIT, B_OUT} state_t;

  state_t                 state_r;
  logic [PIX_W-1:0]       px_r, py_r;
  logic signed [FX_W-1:0] cr_r, ci_r;
  logic signed [FX_W-1:0] zr_r, zi_r, zr2_r, zi2_r, zrzi_r;
  logic [CNT_W-1:0]       n_r;
  logic [MAG_W-1:0]       mag_r;
  logic                   go_r;
  logic                   out_valid_r;
  logic [PIX_W-1:0]       out_x_r, out_y_r;
  logic [CNT_W-1:0]       out_count_r;
  logic                   out_interior_r;
  logic [MAG_W-1:0]       out_mag_r;

  logic                   vld_rr, vld_ii, vld_ri;
  logic signed [FX_W-1:0] p_rr, p_ii, p_ri;
  logic [FX_W-1:0]        mag_sum;
  logic [MAG_W-1:0]       mag_sat;
  logic                   keep_going;
  logic signed [FX_W-1:0] zr_nxt, zi_nxt;
  logic                   out_free;

  // escape test on the unclamped sum of squares
  assign mag_sum    = {1'b0, zr2_r[MAG_W-1:0]} + {1'b0, zi2_r[MAG_W-1:0]};
  assign mag_sat    = mag_sum[FX_W-1] ? {MAG_W{1'b1}} : mag_sum[MAG_W-1:0];
  assign keep_going = (n_r < cfg.max_iterations) && (mag_sum < {1'b0, cfg.escape_radius_sq});

  // z = z*z + c
  assign zi_nxt = mebt_pkg::sat_fx((WIDE_W'(zrzi_r) <<< 1) + WIDE_W'(ci_r));
  assign zr_nxt = mebt_pkg::sat_fx(WIDE_W'(zr2_r) - WIDE_W'(zi2_r) + WIDE_W'(cr_r));

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == B_IDLE) && !q_empty;

  // three products of one iteration run side by side
  mebt_fxmul u_mul_rr (
    .clk (clk), .rst_n (rst_n), .go (go_r), .a (zr_r), .b (zr_r), .p_vld (vld_rr), .p (p_rr)
  );
  mebt_fxmul u_mul_ii (
    .clk (clk), .rst_n (rst_n), .go (go_r), .a (zi_r), .b (zi_r), .p_vld (vld_ii), .p (p_ii)
  );
  mebt_fxmul u_mul_ri (
    .clk (clk), .rst_n (rst_n), .go (go_r), .a (zr_r), .b (zi_r), .p_vld (vld_ri), .p (p_ri)
  );

  // iteration sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            px_r   <= pop_item.pixel_x;
            py_r   <= pop_item.pixel_y;
            cr_r   <= pop_item.c_real;
            ci_r   <= pop_item.c_imag;
            zr_r   <= '0;
            zi_r   <= '0;
            zr2_r  <= '0;
            zi2_r  <= '0;
            zrzi_r <= '0;
            mag_r  <= '0;
            if (pop_item.interior) begin
              n_r     <= cfg.max_iterations;
              state_r <= B_OUT;
            end else begin
              n_r     <= '0;
              state_r <= B_STEP;
            end
          end
        end
        B_STEP: begin
          if (keep_going) begin
            zr_r    <= zr_nxt;
            zi_r    <= zi_nxt;
            n_r     <= n_r + 1'b1;
            go_r    <= 1'b1;
            state_r <= B_WAIT;
          end else begin
            mag_r   <= mag_sat;
            state_r <= B_OUT;
          end
        end
        B_WAIT: begin
          if (vld_rr && vld_ii && vld_ri) begin
            zr2_r   <= p_rr;
            zi2_r   <= p_ii;
            zrzi_r  <= p_ri;
            state_r <= B_STEP;
          end
        end
        B_OUT: begin
          if (out_free) begin
            out_x_r        <= px_r;
            out_y_r        <= py_r;
            out_count_r    <= n_r;
            out_interior_r <= (n_r >= cfg.max_iterations);
            out_mag_r      <= mag_r;
            out_valid_r    <= 1'b1;
            state_r        <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_x                  = out_x_r;
  assign out_y                  = out_y_r;
  assign out_iteration_count    = out_count_r;
  assign out_interior           = out_interior_r;
  assign out_final_magnitude_sq = out_mag_r;

endmodule

### src/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time engine. Each pixel transaction (column, row) is
// mapped to c = (p - size/2) * pixel_step + center in signed Q8.40, checked
// against the main cardioid and the period-2 bulb, and otherwise iterated as
// z = z*z + c until max_iterations or |z|^2 >= escape_radius_sq. One result
// transaction comes back per pixel, in order, with the pixel position, the
// count, an interior flag and the final |z|^2 clamped to 2^47-1. A front
// classifier (which tests the cardioid and bulb only for a point inside
// |c| < 2 on both axes) feeds a two-entry queue; the back iterator handles
// one pixel at a time, each iteration through the four-stage 48x48
// multipliers in its loop, and a cardioid or bulb point skips the loop.
// Registers are to be written through the cfg port only while no pixel is in
// flight; the block does not enforce this. cfg_ready is always high.
module mandelbrot_escape_time_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mebt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mebt_pkg::FX_W-1:0]          cfg_data,
  // pixel input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mebt_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [mebt_pkg::PIX_W-1:0]         in_pixel_y,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mebt_pkg::PIX_W-1:0]         out_x,
  output logic [mebt_pkg::PIX_W-1:0]         out_y,
  output logic [mebt_pkg::CNT_W-1:0]         out_iteration_count,
  output logic                               out_interior,
  output logic [mebt_pkg::MAG_W-1:0]         out_final_magnitude_sq
);

  localparam int FX_W  = mebt_pkg::FX_W;
  localparam int MAG_W = mebt_pkg::MAG_W;
  localparam int CNT_W = mebt_pkg::CNT_W;

  mebt_pkg::cfg_t  cfg_r;
  logic            push, q_full, pop, q_empty;
  mebt_pkg::item_t push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_real      <= '0;
      cfg_r.center_imag      <= '0;
      cfg_r.pixel_step       <= mebt_pkg::PIXEL_STEP_RESET;
      cfg_r.max_iterations   <= mebt_pkg::MAX_ITER_RESET;
      cfg_r.escape_radius_sq <= mebt_pkg::ESCAPE_RADIUS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mebt_pkg::REG_CENTER_REAL:   cfg_r.center_real      <= cfg_data;
        mebt_pkg::REG_CENTER_IMAG:   cfg_r.center_imag      <= cfg_data;
        mebt_pkg::REG_PIXEL_STEP:    cfg_r.pixel_step       <= cfg_data[MAG_W-1:0];
        mebt_pkg::REG_MAX_ITER:      cfg_r.max_iterations   <= cfg_data[CNT_W-1:0];
        mebt_pkg::REG_ESCAPE_RADIUS: cfg_r.escape_radius_sq <= cfg_data[MAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // mapping and cardioid / bulb classification
  mebt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .push       (push),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  // decoupling queue
  mebt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // escape-time iteration
  mebt_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .pop                    (pop),
    .pop_item               (pop_item),
    .q_empty                (q_empty),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_x                  (out_x),
    .out_y                  (out_y),
    .out_iteration_count    (out_iteration_count),
    .out_interior           (out_interior),
    .out_final_magnitude_sq (out_final_magnitude_sq)
  );

endmodule
